>>> sv/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int MAX_PROCS_DEF = 16;

   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;
   localparam int TIME_W    = 21;
   localparam int PROC_ID_W = 5;

   // One row of the process table.
   typedef struct packed {
      logic [ARR_W-1:0]   arr;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

>>> sv/nonpreemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core
// Loads a set of processes into a table and schedules them without preemption
// by priority, emitting start, finish, turnaround and waiting times per process.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Moves                                   Transfer when
//   req_     in         arrival, burst, priority, last marker   req_valid & req_ready
//   rsp_     out        id, start, finish, turnaround, waiting  rsp_valid & rsp_ready
//
// Each transfer loads one process. Once the last process is in, each decision
// scans the n loaded processes of the table one row per cycle through the
// single read port of the table memory; the read data is registered before
// the compare, and the result is formed once the scan ends.
// Reset is synchronous; it clears the load count, the done flags, the state
// machine and the output valid. The table contents are left as they are.
// One finished result waits in the output register while the next decision is
// scanned. req_ready is low from the transfer of the last process until the
// final result of that schedule has entered the output register.

module nonpreemptive_priority_scheduler_core #(
   parameter int MAX_PROCS = nps_pkg::MAX_PROCS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [nps_pkg::ARR_W-1:0]      req_arrival_time,
   input  logic [nps_pkg::BURST_W-1:0]    req_burst_time,
   input  logic [nps_pkg::PRIO_W-1:0]     req_priority_level,
   input  logic                           req_last_in,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [nps_pkg::PROC_ID_W-1:0]  rsp_proc_id,
   output logic [nps_pkg::TIME_W-1:0]     rsp_start_time,
   output logic [nps_pkg::TIME_W-1:0]     rsp_finish_time,
   output logic [nps_pkg::TIME_W-1:0]     rsp_turnaround,
   output logic [nps_pkg::TIME_W-1:0]     rsp_waiting,
   output logic                           rsp_last_out
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TW    = nps_pkg::TIME_W;

   // Process table: one synchronous memory, written during loading and read
   // during scans. The two phases never overlap, so no forwarding is needed.
   nps_pkg::entry_type mem [MAX_PROCS];
   nps_pkg::entry_type rd_data_ff;

   nps_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]            cnt_ff;
   logic [nps_pkg::ARR_W-1:0]   min_arr_ff;
   logic [TW-1:0]               cur_time_ff;
   logic [CNT_W-1:0]            issue_ff;
   logic                        cmp_vld_ff;
   logic [IDX_W-1:0]            cmp_idx_ff;
   logic [MAX_PROCS-1:0]        done_ff;
   logic [CNT_W-1:0]            dec_ff;

   // Best arrived candidate and best not-yet-arrived candidate of the scan.
   logic                        found_ff;
   nps_pkg::entry_type          best_ff;
   logic [IDX_W-1:0]            best_idx_ff;
   logic                        pend_ff;
   nps_pkg::entry_type          pend_rec_ff;
   logic [IDX_W-1:0]            pend_idx_ff;

   logic                        rsp_valid_ff;
   logic [nps_pkg::PROC_ID_W-1:0] rsp_proc_id_ff;
   logic [TW-1:0]               rsp_start_ff, rsp_finish_ff, rsp_turn_ff, rsp_wait_ff;
   logic                        rsp_last_ff;

   // Control from the state machine.
   logic scan_start, issue_en, rsp_load, sched_done;

   logic                        req_xfer, store_en;
   logic [nps_pkg::ARR_W-1:0]   min_arr_next;
   logic                        last_cmp, last_dec;

   logic                        cand_live, cand_arrived, beats_best, beats_pend;
   nps_pkg::entry_type          cand;

   nps_pkg::entry_type          pick;
   logic [IDX_W-1:0]            pick_idx;
   logic [IDX_W:0]              pick_id_full;
   logic [TW-1:0]               start_t, finish_t, wait_t, turn_t;

   // ------------------------------------------------------------------------
   // Loading
   // ------------------------------------------------------------------------
   assign req_xfer = req_valid && req_ready;
   assign store_en = req_xfer && (cnt_ff < CNT_W'(MAX_PROCS));

   // Earliest arrival of the set, tracked as rows are stored; it is the
   // starting time of the schedule.
   always_comb begin
      if (cnt_ff == '0) begin
         min_arr_next = req_arrival_time;
      end else if (req_arrival_time < min_arr_ff) begin
         min_arr_next = req_arrival_time;
      end else begin
         min_arr_next = min_arr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[cnt_ff[IDX_W-1:0]] <= '{arr: req_arrival_time, burst: req_burst_time,
                                     prio: req_priority_level};
      end
      rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
   end

   // ------------------------------------------------------------------------
   // Scan compare: one table row per cycle, in the cycle after its read
   // ------------------------------------------------------------------------
   assign cand         = rd_data_ff;
   assign cand_live    = cmp_vld_ff && !done_ff[cmp_idx_ff];
   assign cand_arrived = TW'(cand.arr) <= cur_time_ff;

   // Rows arrive in ascending id order, so a strict win keeps the lower id on ties.
   assign beats_best = !found_ff || (cand.prio < best_ff.prio) ||
                       ((cand.prio == best_ff.prio) && (cand.arr < best_ff.arr));

   // With nothing arrived, time jumps to the earliest pending arrival and the
   // pick is the best among processes arriving exactly then.
   assign beats_pend = !pend_ff || (cand.arr < pend_rec_ff.arr) ||
                       ((cand.arr == pend_rec_ff.arr) && (cand.prio < pend_rec_ff.prio));

   assign last_cmp = cmp_vld_ff && ((CNT_W'({1'b0, cmp_idx_ff}) + 1'b1) == cnt_ff);
   assign last_dec = (dec_ff + 1'b1) == cnt_ff;

   // ------------------------------------------------------------------------
   // Result of one decision
   // ------------------------------------------------------------------------
   assign pick         = found_ff ? best_ff : pend_rec_ff;
   assign pick_idx     = found_ff ? best_idx_ff : pend_idx_ff;
   assign pick_id_full = {1'b0, pick_idx} + 1'b1;
   assign start_t      = found_ff ? cur_time_ff : TW'(pend_rec_ff.arr);
   assign finish_t     = start_t + TW'(pick.burst);
   assign wait_t       = start_t - TW'(pick.arr);
   assign turn_t       = wait_t + TW'(pick.burst);

   // ------------------------------------------------------------------------
   // State machine
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nps_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      scan_start = 1'b0;
      issue_en   = 1'b0;
      rsp_load   = 1'b0;
      sched_done = 1'b0;
      unique case (state_ff)
         nps_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid && req_last_in) begin
               scan_start = 1'b1;
               state_in   = nps_pkg::ST_SCAN;
            end
         end
         nps_pkg::ST_SCAN: begin
            issue_en = issue_ff < cnt_ff;
            if (last_cmp) begin
               state_in = nps_pkg::ST_RESULT;
            end
         end
         nps_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if (last_dec) begin
                  sched_done = 1'b1;
                  state_in   = nps_pkg::ST_LOAD;
               end else begin
                  scan_start = 1'b1;
                  state_in   = nps_pkg::ST_SCAN;
               end
            end
         end
         default: begin
            state_in = nps_pkg::ST_LOAD;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         done_ff    <= '0;
         dec_ff     <= '0;
         issue_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         cmp_vld_ff <= issue_en;
         if (issue_en) begin
            issue_ff <= issue_ff + 1'b1;
         end

         if (scan_start) begin
            issue_ff <= '0;
            found_ff <= 1'b0;
            pend_ff  <= 1'b0;
         end else if (cand_live) begin
            if (cand_arrived && beats_best) begin
               found_ff <= 1'b1;
            end
            if (!cand_arrived && beats_pend) begin
               pend_ff <= 1'b1;
            end
         end

         // End of the schedule: the load count, done flags and decision count are cleared for the next set.
         if (sched_done) begin
            cnt_ff  <= '0;
            done_ff <= '0;
            dec_ff  <= '0;
         end else begin
            if (store_en) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (rsp_load) begin
               done_ff[pick_idx] <= 1'b1;
               dec_ff            <= dec_ff + 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (store_en) begin
         min_arr_ff <= min_arr_next;
      end
      if (req_xfer && req_last_in) begin
         cur_time_ff <= TW'(min_arr_next);
      end else if (rsp_load) begin
         cur_time_ff <= finish_t;
      end

      cmp_idx_ff <= issue_ff[IDX_W-1:0];

      if (cand_live && cand_arrived && beats_best) begin
         best_ff     <= cand;
         best_idx_ff <= cmp_idx_ff;
      end
      if (cand_live && !cand_arrived && beats_pend) begin
         pend_rec_ff <= cand;
         pend_idx_ff <= cmp_idx_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_proc_id_ff <= nps_pkg::PROC_ID_W'(pick_id_full);
         rsp_start_ff   <= start_t;
         rsp_finish_ff  <= finish_t;
         rsp_turn_ff    <= turn_t;
         rsp_wait_ff    <= wait_t;
         rsp_last_ff    <= last_dec;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_proc_id     = rsp_proc_id_ff;
   assign rsp_start_time  = rsp_start_ff;
   assign rsp_finish_time = rsp_finish_ff;
   assign rsp_turnaround  = rsp_turn_ff;
   assign rsp_waiting     = rsp_wait_ff;
   assign rsp_last_out    = rsp_last_ff;

endmodule

>>> sv/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks of the scheduler core, bound into the core module.
// ----------------------------------------------------------------------------
module nps_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_last_in,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [nps_pkg::PROC_ID_W-1:0]  rsp_proc_id,
   input logic [nps_pkg::TIME_W-1:0]     rsp_start_time,
   input logic [nps_pkg::TIME_W-1:0]     rsp_finish_time,
   input logic [nps_pkg::TIME_W-1:0]     rsp_turnaround,
   input logic [nps_pkg::TIME_W-1:0]     rsp_waiting,
   input logic                           rsp_last_out
);

   // A stalled result keeps its id, start and finish times and last marker.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_proc_id) && $stable(rsp_start_time) &&
         $stable(rsp_finish_time) && $stable(rsp_last_out))
      else $error("rsp payload changed while stalled");

   // Turnaround exceeds waiting by exactly the run length.
   a_times: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         nps_pkg::TIME_W'(rsp_turnaround - rsp_waiting) ==
         nps_pkg::TIME_W'(rsp_finish_time - rsp_start_time))
      else $error("turnaround, waiting and run length disagree");

   // The last process closes loading until the schedule is out.
   a_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_in |=> !req_ready)
      else $error("loading still open after the last process");

   // A new result only appears while the scheduler is busy, never during loading.
   a_new_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while loading");

endmodule

bind nonpreemptive_priority_scheduler_core nps_checker u_nps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_in     (req_last_in),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_proc_id     (rsp_proc_id),
   .rsp_start_time  (rsp_start_time),
   .rsp_finish_time (rsp_finish_time),
   .rsp_turnaround  (rsp_turnaround),
   .rsp_waiting     (rsp_waiting),
   .rsp_last_out    (rsp_last_out)
);
